FILE: rtl/core/mcpwm_pkg.sv
// Shared types and constants of the multi-channel PWM generator.
`default_nettype none

package mcpwm_pkg;

    // Field widths of the item and result formats.
    localparam int PIN_IDX_W  = 4;
    localparam int DUTY_W     = 10;
    localparam int PERIOD_W   = 10;
    localparam int LEVELS_W   = 16;
    localparam int COUNT_W    = 10;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MASK_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MASK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT    = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 10'd1000;
    localparam logic [DUTY_W-1:0]   DUTY_LIMIT_RESET = 10'd999;

    // Item kinds.
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_DUTY = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [PIN_IDX_W-1:0] pin_index;
        logic [DUTY_W-1:0]    duty_value;
    } mcpwm_in_t;

    typedef struct packed {
        logic [LEVELS_W-1:0] pin_levels;
        logic [COUNT_W-1:0]  count_now;
    } mcpwm_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/mcpwm_duty_mem.sv
// Duty table memory with per-entry valid bits and a registered read port.
`default_nettype none

module mcpwm_duty_mem import mcpwm_pkg::*; #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rd_raw_reg;
    logic              rd_hit_reg;

    // An entry that was never written reads as zero, its reset value.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_raw_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/core/multi_channel_pwm_generator.sv
// Top level of the multi-channel PWM generator for active-low LED pins.
`default_nettype none

//  Channel  Direction  Ports                        Carries
//  s_       in         s_valid s_ready s_data       tick or duty write item
//  m_       out        m_valid m_ready m_data       pin levels and counter
//  cfg_     in         cfg_we cfg_index cfg_wdata   register writes
//
// A duty write stores its entry at the accepting edge, then passes through
// ST_DONE to the result register. A tick scans the duty table, which has one
// read port, one pin per cycle; after the last pin its result passes through
// ST_DONE to the result register. The next item is taken once a result has
// loaded.
// Reset is synchronous and active low; all pins come out of reset high.
// A new item is taken only once the previous one has reached the result
// register; a stalled result holds there until m_ready takes it.

module multi_channel_pwm_generator import mcpwm_pkg::*; #(
    parameter int PIN_COUNT  = 16,
    parameter int COUNT_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mcpwm_in_t             s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mcpwm_out_t            m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ADDR_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    // Width that holds both the counter and the period length for compares.
    localparam int CMP_W  = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;
    localparam logic [ADDR_W-1:0] LAST_PIN = ADDR_W'(PIN_COUNT - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Configuration registers.
    logic [PIN_COUNT-1:0]  active_mask_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [DUTY_W-1:0]     duty_limit_reg;

    // Control and state.
    logic [1:0]            state_reg, state_next;
    logic [COUNT_BITS-1:0] counter_reg, counter_next;
    logic [PIN_COUNT-1:0]  level_reg, level_next;
    logic                  issue_reg, issue_next;
    logic [ADDR_W-1:0]     scan_addr_reg, scan_addr_next;
    logic                  proc_live_reg;
    logic [ADDR_W-1:0]     proc_pin_reg;
    logic                  m_valid_reg, m_valid_next;
    mcpwm_out_t            m_data_reg;

    logic                  accept;
    logic                  out_load;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [DUTY_W-1:0]     duty_clamped;
    logic                  pin_ok;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  mem_wr_en;
    logic [COUNT_BITS-1:0] rd_duty;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // Configuration writes; the user must keep the block idle (unenforced).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_mask_reg <= '0;
            period_reg      <= PERIOD_RESET;
            duty_limit_reg  <= DUTY_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ACTIVE_MASK: begin
                    active_mask_reg <= PIN_COUNT'(cfg_wdata[MASK_W-1:0]);
                end
                CFG_PERIOD_LENGTH: begin
                    period_reg <= cfg_wdata[PERIOD_W-1:0];
                end
                CFG_DUTY_LIMIT: begin
                    duty_limit_reg <= cfg_wdata[DUTY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Duty write path: clamp, then store only for an existing, active pin.
    assign duty_clamped = (s_data.duty_value > duty_limit_reg) ? duty_limit_reg
                                                               : s_data.duty_value;
    assign pin_ok    = (32'(s_data.pin_index) < PIN_COUNT);
    assign wr_addr   = ADDR_W'(s_data.pin_index);
    assign mem_wr_en = accept && (s_data.mode == MODE_DUTY) && pin_ok
                       && active_mask_reg[wr_addr];

    mcpwm_duty_mem #(
        .DEPTH  (PIN_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_BITS)
    ) u_duty_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_addr),
        .wr_data (COUNT_BITS'(duty_clamped)),
        .rd_en   (issue_reg),
        .rd_addr (scan_addr_reg),
        .rd_data (rd_duty)
    );

    // The counter wraps when the increment reaches the period length, which
    // also covers a period lowered below the current count.
    assign cnt_inc = COUNT_BITS'(counter_reg + 1'b1);

    always_comb begin
        state_next     = state_reg;
        counter_next   = counter_reg;
        issue_next     = issue_reg;
        scan_addr_next = scan_addr_reg;
        level_next     = level_reg;
        out_load       = 1'b0;

        // Per-pin update for the entry read in the previous cycle.
        if (proc_live_reg && active_mask_reg[proc_pin_reg] && (rd_duty != '0)) begin
            if (counter_reg == '0) begin
                level_next[proc_pin_reg] = 1'b0;
            end else if ((CMP_W'(rd_duty) < CMP_W'(period_reg))
                         && (rd_duty == counter_reg)) begin
                level_next[proc_pin_reg] = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.mode == MODE_TICK) begin
                        if (CMP_W'(cnt_inc) >= CMP_W'(period_reg)) begin
                            counter_next = '0;
                        end else begin
                            counter_next = cnt_inc;
                        end
                        issue_next     = 1'b1;
                        scan_addr_next = '0;
                        state_next     = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (issue_reg) begin
                    if (scan_addr_reg == LAST_PIN) begin
                        issue_next = 1'b0;
                    end else begin
                        scan_addr_next = scan_addr_reg + 1'b1;
                    end
                end else if (proc_live_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            counter_reg   <= '0;
            level_reg     <= '1;
            issue_reg     <= 1'b0;
            scan_addr_reg <= '0;
            proc_live_reg <= 1'b0;
            proc_pin_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            level_reg     <= level_next;
            issue_reg     <= issue_next;
            scan_addr_reg <= scan_addr_next;
            proc_live_reg <= issue_reg;
            proc_pin_reg  <= scan_addr_reg;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Result register; the payload needs no reset.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.pin_levels <= LEVELS_W'(level_reg);
            m_data_reg.count_now  <= COUNT_W'(counter_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The counter moves only on the edge that accepts a tick.
    a_counter_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && (s_data.mode == MODE_TICK)) |=> $stable(counter_reg))
        else $error("counter changed without an accepted tick");

    // Entries are processed only during a scan.
    a_proc_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_live_reg |-> (state_reg == ST_SCAN))
        else $error("duty entry processed outside a scan");

    // Pin levels change only through the per-pin update.
    a_levels_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        !proc_live_reg |=> $stable(level_reg))
        else $error("pin levels changed outside a scan");

    // A result appears only when an item has finished.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised without a finished item");

endmodule

`default_nettype wire
